>>> rtl/core/twrtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrtc_pkg
// shared types and constants of the three-wire serial clock chip master
// ----------------------------------------------------------------------------
package twrtc_pkg;

    // input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // bit positions inside the pin level word
    localparam int PIN_EN  = 0;
    localparam int PIN_CLK = 1;
    localparam int PIN_VAL = 2;
    localparam int PIN_DE  = 3;

    localparam int PIN_W   = 4;
    localparam int STEP_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 16;

    // phase count at which the frame is closed
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd32;

    // request kind after decode
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    // classified request passed from front to back
    typedef struct packed {
        t_kind               kind;
        logic [SHIFT_W-1:0]  load;
        logic                io;
    } t_req;

    // one result item
    typedef struct packed {
        logic              enable_level;
        logic              clock_level;
        logic              io_drive_value;
        logic              io_drive_enable;
        logic [BYTE_W-1:0] read_data;
        logic              done_res;
        logic              busy_res;
        logic              rejected;
    } t_res;

endpackage : twrtc_pkg
`default_nettype wire

>>> rtl/core/twrtc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrtc_front
// accepts requests, decodes the function and builds the shift word
// ----------------------------------------------------------------------------
module twrtc_front
    import twrtc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_func,
    input  wire logic [7:0]    i_command_byte,
    input  wire logic [7:0]    i_write_data,
    input  wire logic          i_io_sample,
    output logic               o_req_valid,
    output t_req               o_req,
    input  wire logic          i_req_ready
);

    logic r_valid;
    t_req r_req;
    t_req n_req;

    assign o_ready     = !r_valid || i_req_ready;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_comb begin
        n_req.io   = i_io_sample;
        n_req.load = {8'h00, i_command_byte};
        case (i_func)
            FUNC_WRITE: begin
                n_req.kind = KIND_WRITE;
                n_req.load = {i_write_data, i_command_byte};
            end
            FUNC_READ: begin
                n_req.kind = KIND_READ;
            end
            default: begin
                n_req.kind = KIND_TICK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

endmodule : twrtc_front
`default_nettype wire

>>> rtl/core/twrtc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrtc_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module twrtc_queue
    import twrtc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_req i_push_req,
    output logic      o_pop_valid,
    output t_req      o_pop_req,
    input  wire logic i_pop_ready
);

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_req    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule : twrtc_queue
`default_nettype wire

>>> rtl/core/twrtc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrtc_back
// frame sequencer: steps the serial lines and registers each result
// ----------------------------------------------------------------------------
module twrtc_back
    import twrtc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire t_req i_req,
    output logic      o_req_ready,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_ready
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FRAME = 2'b10
    } t_state;

    t_state             r_state,     n_state;
    logic               r_is_read,   n_is_read;
    logic [STEP_W-1:0]  r_step,      n_step;
    logic [SHIFT_W-1:0] r_out_shift, n_out_shift;
    logic [BYTE_W-1:0]  r_in_shift,  n_in_shift;
    logic [PIN_W-1:0]   r_pins,      n_pins;
    logic               r_res_valid;
    t_res               r_res;
    t_res               n_res;
    logic               fire;
    logic               high;
    logic               rej;
    logic               done;

    assign o_req_ready = !r_res_valid || i_res_ready;
    assign fire        = i_req_valid && o_req_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign high        = r_step[0];

    always_comb begin
        n_state     = r_state;
        n_is_read   = r_is_read;
        n_step      = r_step;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_pins      = r_pins;
        rej         = 1'b0;
        done        = 1'b0;
        if (i_req.kind != KIND_TICK) begin
            if (r_state == ST_FRAME) begin
                rej = 1'b1;
            end else begin
                n_state     = ST_FRAME;
                n_is_read   = (i_req.kind == KIND_READ);
                n_step      = '0;
                n_out_shift = i_req.load;
                n_pins      = '0;
                n_pins[PIN_EN] = 1'b1;
                n_pins[PIN_DE] = 1'b1;
            end
        end else if (r_state == ST_FRAME) begin
            if (r_step >= LAST_STEP) begin
                // closing phase
                n_state   = ST_IDLE;
                n_is_read = 1'b0;
                n_step    = '0;
                n_pins    = '0;
                done      = 1'b1;
            end else begin
                n_pins          = '0;
                n_pins[PIN_EN]  = 1'b1;
                n_pins[PIN_CLK] = high;
                if (r_is_read && r_step[4]) begin
                    // data line released, sample on the high phase
                    if (high) begin
                        n_in_shift = {i_req.io, r_in_shift[BYTE_W-1:1]};
                    end
                end else begin
                    n_pins[PIN_DE]  = 1'b1;
                    n_pins[PIN_VAL] = r_out_shift[0];
                    if (high) begin
                        n_out_shift = {1'b0, r_out_shift[SHIFT_W-1:1]};
                    end
                end
                n_step = r_step + 6'd1;
            end
        end
    end

    always_comb begin
        n_res.enable_level    = n_pins[PIN_EN];
        n_res.clock_level     = n_pins[PIN_CLK];
        n_res.io_drive_value  = n_pins[PIN_VAL];
        n_res.io_drive_enable = n_pins[PIN_DE];
        n_res.read_data       = n_in_shift;
        n_res.done_res        = done;
        n_res.busy_res        = (n_state == ST_FRAME);
        n_res.rejected        = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_read   <= 1'b0;
            r_step      <= '0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_pins      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_state     <= n_state;
                r_is_read   <= n_is_read;
                r_step      <= n_step;
                r_out_shift <= n_out_shift;
                r_in_shift  <= n_in_shift;
                r_pins      <= n_pins;
            end
            if (o_req_ready) begin
                r_res_valid <= i_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

endmodule : twrtc_back
`default_nettype wire

>>> rtl/core/three_wire_rtc_serial_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// master for a three-wire serial clock chip link (enable, clock, data)
// ----------------------------------------------------------------------------
// usage
//   input channel i_in_valid / o_in_ready carries one request per item:
//   a tick (func 0 or 3), a write frame start (func 1) or a read frame
//   start (func 2), with command byte, write data and the sampled data line
//   output channel o_out_valid / i_out_ready returns one result per request:
//   the line levels after that request, the read shift register, and the
//   done, busy and rejected flags
//   each tick moves the serial line by one clock phase; a frame takes one
//   start request plus 33 ticks (32 bit phases and a closing phase)
//   a result passes the front register, the queue and the result register
//   in that order after its request is accepted
//   throughput: one request per cycle while the result register is not
//   held by i_out_ready, set by the sequencer in the back part
//   a stalled receiver fills the result register, then the two-entry queue,
//   then the front register before o_in_ready drops; nothing is lost
//   reset clears the sequencer to idle with all lines low and released
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master
    import twrtc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // request channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_command_byte,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_io_sample,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_enable_level,
    output logic            o_clock_level,
    output logic            o_io_drive_value,
    output logic            o_io_drive_enable,
    output logic [7:0]      o_read_data,
    output logic            o_done_res,
    output logic            o_busy_res,
    output logic            o_rejected
);

    // front to queue
    logic f_valid;
    logic f_ready;
    t_req f_req;
    // queue to back
    logic q_valid;
    logic q_ready;
    t_req q_req;
    // back result
    t_res res;

    // decode and register each request
    twrtc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_func         (i_func),
        .i_command_byte (i_command_byte),
        .i_write_data   (i_write_data),
        .i_io_sample    (i_io_sample),
        .o_req_valid    (f_valid),
        .o_req          (f_req),
        .i_req_ready    (f_ready)
    );

    // decouples front and back so each can stall on its own
    twrtc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_req   (f_req),
        .o_pop_valid  (q_valid),
        .o_pop_req    (q_req),
        .i_pop_ready  (q_ready)
    );

    // frame sequencer with registered result
    twrtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .i_req       (q_req),
        .o_req_ready (q_ready),
        .o_res_valid (o_out_valid),
        .o_res       (res),
        .i_res_ready (i_out_ready)
    );

    assign o_enable_level    = res.enable_level;
    assign o_clock_level     = res.clock_level;
    assign o_io_drive_value  = res.io_drive_value;
    assign o_io_drive_enable = res.io_drive_enable;
    assign o_read_data       = res.read_data;
    assign o_done_res        = res.done_res;
    assign o_busy_res        = res.busy_res;
    assign o_rejected        = res.rejected;

endmodule : three_wire_rtc_serial_master
`default_nettype wire
